/* src/assert_macros.svh */
// assertion macros shared by the list store rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)

`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

/* src/pls_pkg.sv */
// types and constants for the positional list store
`timescale 1ns / 1ps

package pls_pkg;

    localparam int FUNC_W    = 2;
    localparam int POS_W     = 6;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 16;
    localparam int STAT_W    = 2;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 5;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_SEARCH = 2'd2
    } pls_func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } pls_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DONE
    } pls_state_t;

    // per-cell command: load, take from a neighbour, compare
    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic compare;
    } pls_cell_cmd_t;

endpackage

/* src/pls_cell.sv */
// one list slot: holds a key and payload, shifts to or from its neighbours, compares
`timescale 1ns / 1ps

module pls_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pls_pkg::pls_cell_cmd_t     cmd,
    input  logic [pls_pkg::KEY_W-1:0]  new_key,
    input  logic [pls_pkg::PAY_W-1:0]  new_pay,
    input  logic [pls_pkg::KEY_W-1:0]  left_key,
    input  logic [pls_pkg::PAY_W-1:0]  left_pay,
    input  logic [pls_pkg::KEY_W-1:0]  right_key,
    input  logic [pls_pkg::PAY_W-1:0]  right_pay,
    output logic [pls_pkg::KEY_W-1:0]  key_q,
    output logic [pls_pkg::PAY_W-1:0]  pay_q,
    output logic                       match_q
);
    import pls_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic             match_reg, match_next;

    always_comb begin
        key_next   = key_reg;
        pay_next   = pay_reg;
        match_next = match_reg;
        priority if (cmd.load) begin
            key_next = new_key;
            pay_next = new_pay;
        end else if (cmd.take_left) begin
            key_next = left_key;
            pay_next = left_pay;
        end else if (cmd.take_right) begin
            key_next = right_key;
            pay_next = right_pay;
        end else begin
            key_next = key_reg;
            pay_next = pay_reg;
        end
        if (cmd.compare) begin
            match_next = (key_reg == new_key);
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign key_q   = key_reg;
    assign pay_q   = pay_reg;
    assign match_q = match_reg;

endmodule

/* src/pls_pick.sv */
// picks the lowest requesting cell and reads out its index, key and payload
`timescale 1ns / 1ps

module pls_pick #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  logic [N-1:0]               req,
    input  logic [pls_pkg::KEY_W-1:0]  keys [N],
    input  logic [pls_pkg::PAY_W-1:0]  pays [N],
    output logic [N-1:0]               hit,
    output logic                       any,
    output logic [IW-1:0]              index,
    output logic [pls_pkg::KEY_W-1:0]  key,
    output logic [pls_pkg::PAY_W-1:0]  pay
);
    import pls_pkg::*;

    // isolate lowest set bit
    assign hit = req & (~req + N'(1));
    assign any = |req;

    always_comb begin
        index = '0;
        key   = '0;
        pay   = '0;
        for (int i = 0; i < N; i++) begin
            if (hit[i]) begin
                index = index | IW'(i);
                key   = key | keys[i];
                pay   = pay | pays[i];
            end
        end
    end

endmodule

/* src/positional_list_store.sv */
// positional list store: ordered key/payload list held in a row of shifting cells
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_      | in  | position, entry_key, entry_payload             | func
//  m_      | out | found_index, out_key, out_payload, count_now    | status
//
// each request passes three steps: accept, compare (in every cell, for a search), commit
// commit shifts the affected cells at once and loads the output register; it waits while
// the output register still holds an untaken result
// next request is taken on the cycle after commit
// reset clears the entry count, control and cell match flags; slot keys and payloads are left as they are
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pls_pkg::S_TDATA_W-1:0]  s_tdata,  // position, entry_key, entry_payload
    input  logic [pls_pkg::FUNC_W-1:0]     s_tuser,  // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pls_pkg::M_TDATA_W-1:0]  m_tdata,  // found_index, out_key, out_payload, count_now
    output logic [pls_pkg::STAT_W-1:0]     m_tuser   // status
);
    import pls_pkg::*;

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMPW  = (CW > IDX_W) ? CW : IDX_W;
    localparam int M_PAD = M_TDATA_W - IDX_W - KEY_W - PAY_W - CNT_W;

    pls_state_t state_reg, state_next;

    logic [FUNC_W-1:0] func_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [KEY_W-1:0]  op_key_reg;
    logic [PAY_W-1:0]  op_pay_reg;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [IDX_W-1:0]  m_index_reg, m_index_next;
    logic [KEY_W-1:0]  m_key_reg, m_key_next;
    logic [PAY_W-1:0]  m_pay_reg, m_pay_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    logic accept, out_free, commit, full, empty;
    logic [CW-1:0] idx_cw;

    logic [KEY_W-1:0] key_q [CAPACITY];
    logic [PAY_W-1:0] pay_q [CAPACITY];
    logic [CAPACITY-1:0] match_q;
    logic [CAPACITY-1:0] pick_req;
    pls_cell_cmd_t       cell_cmd [CAPACITY];

    logic [CAPACITY-1:0] pick_hit;
    logic                pick_any;
    logic [IW-1:0]       pick_index;
    logic [KEY_W-1:0]    pick_key;
    logic [PAY_W-1:0]    pick_pay;

    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign idx_cw = CW'(idx_reg);

    // control
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_free   = !m_tvalid_reg || m_tready;
        commit     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // resolve the target index during the compare cycle
    always_comb begin
        logic [CMPW-1:0] praw;
        logic [CMPW-1:0] cnt_w;
        logic [CMPW-1:0] sel;
        praw  = CMPW'(pos_reg[POS_W-2:0]);
        cnt_w = CMPW'(count_reg);
        if (func_reg == FN_REMOVE) begin
            sel = (pos_reg[POS_W-1] || (praw >= cnt_w - CMPW'(1))) ? cnt_w - CMPW'(1) : praw;
        end else begin
            sel = (pos_reg[POS_W-1] || (praw >= cnt_w)) ? cnt_w : praw;
        end
        idx_next = sel[IW-1:0];
    end

    // result and new count at commit
    always_comb begin
        logic [CW-1:0]   found_cw;
        logic [CMPW-1:0] found_w;
        logic [CMPW-1:0] count_w;
        found_cw      = '0;
        count_next    = count_reg;
        m_status_next = ST_OK;
        m_key_next    = '0;
        m_pay_next    = '0;
        unique case (func_reg)
            FN_INSERT: begin
                if (full) begin
                    m_status_next = ST_FULL;
                end else begin
                    found_cw   = idx_cw;
                    count_next = count_reg + CW'(1);
                end
            end
            FN_REMOVE: begin
                if (empty) begin
                    m_status_next = ST_EMPTY;
                end else begin
                    found_cw   = idx_cw;
                    m_key_next = pick_key;
                    m_pay_next = pick_pay;
                    count_next = count_reg - CW'(1);
                end
            end
            FN_SEARCH: begin
                if (pick_any) begin
                    found_cw   = CW'(pick_index);
                    m_key_next = pick_key;
                    m_pay_next = pick_pay;
                end else begin
                    m_status_next = ST_MISS;
                    found_cw      = count_reg;
                end
            end
            default: begin
            end
        endcase
        found_w      = CMPW'(found_cw);
        count_w      = CMPW'(count_next);
        m_index_next = found_w[IDX_W-1:0];
        m_count_next = count_w[CNT_W-1:0];
        m_tvalid_next = commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= s_tuser;
            pos_reg    <= s_tdata[POS_W-1:0];
            op_key_reg <= s_tdata[POS_W+KEY_W-1 -: KEY_W];
            op_pay_reg <= s_tdata[POS_W+KEY_W+PAY_W-1 -: PAY_W];
        end
        if (state_reg == S_CMP) begin
            idx_reg <= idx_next;
        end
        if (commit) begin
            m_status_reg <= m_status_next;
            m_index_reg  <= m_index_next;
            m_key_reg    <= m_key_next;
            m_pay_reg    <= m_pay_next;
            m_count_reg  <= m_count_next;
        end
    end

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CW-1:0] POS_C = CW'(g);
        localparam logic [CW-1:0] NXT_C = CW'(g + 1);

        logic [KEY_W-1:0] left_key, right_key;
        logic [PAY_W-1:0] left_pay, right_pay;

        if (g == 0) begin : g_first
            assign left_key = op_key_reg;
            assign left_pay = op_pay_reg;
        end else begin : g_inner_l
            assign left_key = key_q[g-1];
            assign left_pay = pay_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key = op_key_reg;
            assign right_pay = op_pay_reg;
        end else begin : g_inner_r
            assign right_key = key_q[g+1];
            assign right_pay = pay_q[g+1];
        end

        always_comb begin
            cell_cmd[g] = '0;
            if (commit && func_reg == FN_INSERT && !full) begin
                cell_cmd[g].load      = (POS_C == idx_cw);
                cell_cmd[g].take_left = (POS_C > idx_cw) && (POS_C <= count_reg);
            end
            if (commit && func_reg == FN_REMOVE && !empty) begin
                cell_cmd[g].take_right = (POS_C >= idx_cw) && (NXT_C < count_reg);
            end
            cell_cmd[g].compare = (state_reg == S_CMP) && (func_reg == FN_SEARCH);
        end

        // search wants the first live match, remove wants the target slot
        assign pick_req[g] = (func_reg == FN_SEARCH) ? (match_q[g] && (POS_C < count_reg))
                                                     : (POS_C == idx_cw);

        pls_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cell_cmd[g]),
            .new_key   (op_key_reg),
            .new_pay   (op_pay_reg),
            .left_key  (left_key),
            .left_pay  (left_pay),
            .right_key (right_key),
            .right_pay (right_pay),
            .key_q     (key_q[g]),
            .pay_q     (pay_q[g]),
            .match_q   (match_q[g])
        );
    end

    pls_pick #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_pick (
        .req   (pick_req),
        .keys  (key_q),
        .pays  (pay_q),
        .hit   (pick_hit),
        .any   (pick_any),
        .index (pick_index),
        .key   (pick_key),
        .pay   (pick_pay)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, m_count_reg, m_pay_reg, m_key_reg, m_index_reg};

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `ASSERT_CLK(a_count_hold, aclk, aresetn, !commit |=> $stable(count_reg), "count moved without commit")
    `ASSERT_CLK(a_commit_valid, aclk, aresetn, commit |=> m_tvalid_reg, "commit left no result")
    `ASSERT_CLK(a_pick_onehot, aclk, aresetn, state_reg == S_DONE |-> $onehot0(pick_hit), "more than one cell picked")
    `ASSERT_NEVER(a_full_insert, aclk, aresetn, commit && func_reg == FN_INSERT && full && count_next != count_reg, "insert into full list changed count")

endmodule

/* tb/positional_list_store_tb.sv */
// self-checking testbench for the positional list store: predicts every result and compares it
`timescale 1ns / 1ps

module positional_list_store_tb;
    import pls_pkg::*;

    localparam int          CAPACITY    = 16;
    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 10;
    localparam int          RAND_ITEMS  = 400;
    localparam logic [1:0]  FN_NOP      = 2'd3;   // unused code, leaves the list unchanged but still returns a result
    localparam logic [5:0]  POS_LAST    = 6'h3F;  // -1
    localparam logic [5:0]  POS_MOST_NEG = 6'h20; // -32

    typedef struct packed {
        pls_status_t       status;
        logic [IDX_W-1:0]  found_index;
        logic [KEY_W-1:0]  out_key;
        logic [PAY_W-1:0]  out_payload;
        logic [CNT_W-1:0]  count_now;
    } list_result_t;

    class list_scoreboard;
        logic [KEY_W-1:0] slot_key [CAPACITY];
        logic [PAY_W-1:0] slot_pay [CAPACITY];
        int unsigned      fill;
        list_result_t     awaited_q[$];
        int unsigned      mismatches;
        int unsigned      results_checked;
        int unsigned      requests_noted;
        int unsigned      status_seen [4];

        function new();
            fill = 0;
            mismatches = 0;
            results_checked = 0;
            requests_noted = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned outstanding();
            return awaited_q.size();
        endfunction

        // works out the result of one accepted request and updates the list copy
        function void note_request(logic [1:0] f, logic [5:0] p, logic [KEY_W-1:0] k,
                                   logic [PAY_W-1:0] v);
            list_result_t r;
            int unsigned  idx;
            bit           neg;
            bit           hit;
            neg = p[5];
            hit = 0;
            r = '{ST_OK, '0, '0, '0, '0};
            if (f == FN_INSERT) begin
                if (fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    idx = (neg || p >= fill) ? fill : p;
                    for (int i = fill; i > idx; i--) begin
                        slot_key[i] = slot_key[i-1];
                        slot_pay[i] = slot_pay[i-1];
                    end
                    slot_key[idx] = k;
                    slot_pay[idx] = v;
                    fill++;
                    r.found_index = IDX_W'(idx);
                end
            end else if (f == FN_REMOVE) begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    idx = (neg || p >= fill - 1) ? fill - 1 : p;
                    r.found_index = IDX_W'(idx);
                    r.out_key = slot_key[idx];
                    r.out_payload = slot_pay[idx];
                    for (int i = idx; i + 1 < fill; i++) begin
                        slot_key[i] = slot_key[i+1];
                        slot_pay[i] = slot_pay[i+1];
                    end
                    fill--;
                end
            end else if (f == FN_SEARCH) begin
                for (int i = 0; i < fill && !hit; i++) begin
                    if (slot_key[i] == k) begin
                        hit = 1;
                        r.found_index = IDX_W'(i);
                        r.out_key = slot_key[i];
                        r.out_payload = slot_pay[i];
                    end
                end
                if (!hit) begin
                    r.status = ST_MISS;
                    r.found_index = IDX_W'(fill);
                end
            end
            r.count_now = CNT_W'(fill);
            status_seen[r.status]++;
            requests_noted++;
            awaited_q.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d, logic [STAT_W-1:0] u);
            list_result_t got;
            list_result_t want;
            got.status      = pls_status_t'(u);
            got.found_index = d[IDX_W-1:0];
            got.out_key     = d[IDX_W +: KEY_W];
            got.out_payload = d[IDX_W+KEY_W +: PAY_W];
            got.count_now   = d[IDX_W+KEY_W+PAY_W +: CNT_W];
            results_checked++;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing outstanding: status %0d idx %0d",
                             $realtime, got.status, got.found_index);
                return;
            end
            want = awaited_q.pop_front();
            if (got.status !== want.status || got.found_index !== want.found_index ||
                got.out_key !== want.out_key || got.out_payload !== want.out_payload ||
                got.count_now !== want.count_now) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch on result %0d", $realtime, results_checked);
                    $display("  expected status %0d idx %0d key %h payload %h count %0d",
                             want.status, want.found_index, want.out_key, want.out_payload,
                             want.count_now);
                    $display("  actual   status %0d idx %0d key %h payload %h count %0d",
                             got.status, got.found_index, got.out_key, got.out_payload,
                             got.count_now);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    list_scoreboard sb;
    bit             steady = 1'b0;  // no idling on either side while set

    positional_list_store #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no request moved for %0d cycles", STALL_LIMIT);
        $display("positional_list_store_tb failed");
        $finish;
    end

    task automatic send_request(input logic [1:0] f, input logic [5:0] p,
                                input logic [KEY_W-1:0] k, input logic [PAY_W-1:0] v);
        if (!steady) begin
            while ($urandom_range(99) < 10) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, v, k, p};
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(f, p, k, v);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [5:0] pick_position();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return POS_LAST;
        if (r < 30) return 6'($urandom_range(63));
        return 6'($urandom_range(17));
    endfunction

    initial begin
        logic [5:0]        fill_pos [16];
        logic [KEY_W-1:0]  k;
        logic [1:0]        f;
        int unsigned       r;
        bit                growing;
        int unsigned       phase_left;

        fill_pos = '{6'd0, POS_LAST, 6'd0, 6'd1, 6'd31, POS_MOST_NEG, 6'd2, 6'd5,
                     6'd16, 6'd0, 6'd3, POS_LAST, 6'd12, 6'd8, 6'd14, 6'd15};
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list cases and the unused code
        send_request(FN_REMOVE, 6'd0, 32'h0, 16'h0);
        send_request(FN_SEARCH, 6'd0, 32'hDEAD_BEEF, 16'h0);
        send_request(FN_NOP, 6'd7, 32'h1234_5678, 16'hABCD);
        // fill to capacity at front, back, middle and past-the-end positions
        for (int i = 0; i < 16; i++) begin
            if (i == 0)
                send_request(FN_INSERT, fill_pos[i], 32'hFFFF_FFFF, 16'hFFFF);
            else if (i == 1)
                send_request(FN_INSERT, fill_pos[i], 32'h0, 16'h0);
            else if (i % 5 == 0)
                send_request(FN_INSERT, fill_pos[i], 32'h5A5A_5A5A, 16'($urandom));
            else
                send_request(FN_INSERT, fill_pos[i], $urandom, 16'($urandom));
        end
        send_request(FN_INSERT, 6'd3, 32'hCAFE_F00D, 16'h1111);
        // duplicate key: first match wins
        send_request(FN_SEARCH, 6'd0, 32'h5A5A_5A5A, 16'h0);
        send_request(FN_SEARCH, 6'd0, 32'h1357_9BDF, 16'h0);
        send_request(FN_REMOVE, 6'd5, 32'h0, 16'h0);
        send_request(FN_REMOVE, POS_LAST, 32'h0, 16'h0);
        send_request(FN_REMOVE, 6'd31, 32'h0, 16'h0);
        send_request(FN_REMOVE, 6'd0, 32'h0, 16'h0);
        wait_drained();

        growing = 1'b1;
        phase_left = $urandom_range(60, 20);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 150 && n < 250);
            if (n == 200) wait_drained();
            if (phase_left == 0) begin
                growing = !growing;
                phase_left = $urandom_range(60, 20);
            end
            phase_left--;
            r = $urandom_range(99);
            if (r < 3)
                f = FN_NOP;
            else if (r < 28)
                f = FN_SEARCH;
            else if (growing)
                f = (r < 88) ? FN_INSERT : FN_REMOVE;
            else
                f = (r < 40) ? FN_INSERT : FN_REMOVE;
            // searches mostly hit a stored key, inserts reuse a small pool for duplicates
            if (f == FN_SEARCH && sb.fill > 0 && $urandom_range(99) < 60)
                k = sb.slot_key[$urandom_range(sb.fill - 1)];
            else if (f == FN_INSERT && $urandom_range(99) < 40)
                k = 32'h0F0F_0000 | $urandom_range(7);
            else
                k = $urandom;
            send_request(f, pick_position(), k, 16'($urandom));
        end
        steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests, %0d results checked", sb.requests_noted,
                 sb.results_checked);
        $display("statuses: %0d ok, %0d full, %0d empty, %0d missed searches",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_MISS]);
        if (sb.outstanding() != 0)
            $display("%0d results never arrived", sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("positional_list_store_tb passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("positional_list_store_tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/pls_pkg.sv
src/pls_cell.sv
src/pls_pick.sv
src/positional_list_store.sv
tb/positional_list_store_tb.sv
